### sv/nttu_pkg.sv
`timescale 1ns / 1ps

package nttu_pkg;

    // Prime field: 1005 * 2^20 + 1, primitive root 7
    localparam logic [63:0] MODULUS    = 64'd1053818881;
    localparam logic [63:0] PHI        = 64'd1053818880;
    localparam logic [63:0] PROOT      = 64'd7;
    localparam logic [29:0] P30        = 30'd1053818881;
    localparam logic [30:0] P31        = 31'd1053818881;
    localparam logic [31:0] P32        = 32'd1053818881;
    // Barrett constant floor(2^60 / p)
    localparam logic [30:0] MU         = 31'((64'd1 << 60) / MODULUS);
    localparam int          MAX_STAGES = 20;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic REG_LOG_SIZE     = 1'b0;
    localparam logic REG_INVERSE_MODE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PERM,
        ST_PERM_DRAIN,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_WAIT,
        ST_BF_WR0,
        ST_BF_WR1,
        ST_TW_WAIT
    } state_t;

    typedef enum logic [1:0] {
        WR_LOAD,
        WR_SUM,
        WR_DIFF
    } wr_sel_t;

    typedef enum logic {
        MUL_BFLY,
        MUL_TWID
    } mul_sel_t;

    typedef struct packed {
        logic     mem_we;
        wr_sel_t  wr_sel;
        logic     perm_rd;
        logic     src_scr;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     u_cap;
        logic     tw_init;
        logic     tw_load;
        logic     out_load;
        logic     inverse;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
    } status_t;

    typedef logic [MAX_STAGES:0][29:0] root_tab_t;

    function automatic logic [63:0] pow_mod(input logic [63:0] base_in,
                                            input logic [63:0] e_in);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] e;
        begin
            r = 64'd1;
            b = base_in % MODULUS;
            e = e_in;
            for (int k = 0; k < 31; k++)
            begin
                if (e[0])
                begin
                    r = (r * b) % MODULUS;
                end
                b = (b * b) % MODULUS;
                e = e >> 1;
            end
            return r;
        end
    endfunction

    // Entry s holds the root of order 2^s (or its inverse)
    function automatic root_tab_t root_table(input logic inv);
        root_tab_t   t;
        logic [63:0] w;
        begin
            for (int s = 0; s <= MAX_STAGES; s++)
            begin
                w = pow_mod(PROOT, PHI >> s);
                if (inv)
                begin
                    w = pow_mod(w, PHI - 64'd1);
                end
                t[s] = w[29:0];
            end
            return t;
        end
    endfunction

endpackage

### sv/nttu_modmul.sv
`timescale 1ns / 1ps

// Modular multiplier, registered steps: product, Barrett quotient, remainder, correction
module nttu_modmul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] a,
    input  logic [29:0] b,
    output logic        done,
    output logic [29:0] result
);

    logic [60:0] x_reg;
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [29:0] res_reg;
    logic [2:0]  v_reg;
    logic        done_reg;
    logic [62:0] t_prod;
    logic [61:0] qp_prod;
    logic [31:0] r_fix;

    assign t_prod  = {31'd0, x_reg[60:29]} * {32'd0, nttu_pkg::MU};
    assign qp_prod = {30'd0, q_reg} * {32'd0, nttu_pkg::P30};

    // remainder is below 4p after the estimate
    always_comb
    begin
        if (r_reg >= 32'(3 * nttu_pkg::P32))
        begin
            r_fix = r_reg - 32'(3 * nttu_pkg::P32);
        end
        else if (r_reg >= 32'(2 * nttu_pkg::P32))
        begin
            r_fix = r_reg - 32'(2 * nttu_pkg::P32);
        end
        else if (r_reg >= nttu_pkg::P32)
        begin
            r_fix = r_reg - nttu_pkg::P32;
        end
        else
        begin
            r_fix = r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= {30'd0, a} * {31'd0, b};
        end
        q_reg   <= t_prod[62:31];
        r_reg   <= x_reg[31:0] - qp_prod[31:0];
        res_reg <= r_fix[29:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[1:0], start};
            done_reg <= v_reg[2];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### sv/nttu_datapath.sv
`timescale 1ns / 1ps

module nttu_datapath #(
    parameter int MAX_LOG = 12,
    parameter int LGW     = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nttu_pkg::cmd_t       cmd,
    input  logic [LGW-1:0]       stage,
    input  logic [MAX_LOG-1:0]   addr_a,
    input  logic [MAX_LOG-1:0]   addr_b,
    input  logic [MAX_LOG-1:0]   wr_addr,
    input  logic [MAX_LOG-1:0]   perm_waddr,
    input  logic [29:0]          coefficient,
    output nttu_pkg::status_t    status,
    output logic [29:0]          value,
    output logic [11:0]          out_index
);

    localparam int DEPTH = 1 << MAX_LOG;
    localparam nttu_pkg::root_tab_t FWD_ROOTS = nttu_pkg::root_table(1'b0);
    localparam nttu_pkg::root_tab_t INV_ROOTS = nttu_pkg::root_table(1'b1);

    logic [30:0]        data_mem [DEPTH];
    logic [30:0]        scr_mem  [DEPTH];
    logic [30:0]        data_rd_a_reg;
    logic [30:0]        data_rd_b_reg;
    logic [30:0]        scr_rd_a_reg;
    logic [30:0]        scr_rd_b_reg;
    logic               perm_v_reg;
    logic [MAX_LOG-1:0] perm_addr_reg;
    logic [MAX_LOG-1:0] addr_a_q_reg;
    logic [29:0]        u_reg;
    logic [29:0]        tw_reg;
    logic [29:0]        value_reg;
    logic [11:0]        out_index_reg;

    logic [30:0]        src_u;
    logic [30:0]        src_v;
    logic [29:0]        root;
    logic [30:0]        mul_a;
    logic [29:0]        mul_b;
    logic               mul_done;
    logic [29:0]        mul_res;
    logic [30:0]        wr_data;
    logic [30:0]        red1;
    logic [30:0]        red2;
    logic [MAX_LOG+11:0] idx_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        data_rd_a_reg <= data_mem[addr_a];
        data_rd_b_reg <= data_mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (perm_v_reg)
        begin
            scr_mem[perm_addr_reg] <= data_rd_a_reg;
        end
        scr_rd_a_reg <= scr_mem[addr_a];
        scr_rd_b_reg <= scr_mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_v_reg <= 1'b0;
        end
        else
        begin
            perm_v_reg <= cmd.perm_rd;
        end
    end

    assign src_u = cmd.src_scr ? scr_rd_a_reg : data_rd_a_reg;
    assign src_v = cmd.src_scr ? scr_rd_b_reg : data_rd_b_reg;
    assign root  = cmd.inverse ? INV_ROOTS[stage] : FWD_ROOTS[stage];
    assign mul_a = (cmd.mul_sel == nttu_pkg::MUL_BFLY) ? src_v : {1'b0, tw_reg};
    assign mul_b = (cmd.mul_sel == nttu_pkg::MUL_BFLY) ? tw_reg : root;

    nttu_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    assign status.mul_done = mul_done;

    always_comb
    begin
        case (cmd.wr_sel)
            nttu_pkg::WR_LOAD: wr_data = {1'b0, coefficient};
            nttu_pkg::WR_SUM:  wr_data = {1'b0, u_reg} + {1'b0, mul_res};
            nttu_pkg::WR_DIFF: wr_data = {1'b0, u_reg} + nttu_pkg::P31 - {1'b0, mul_res};
            default:           wr_data = {1'b0, coefficient};
        endcase
    end

    assign red1    = (data_rd_a_reg >= nttu_pkg::P31) ? data_rd_a_reg - nttu_pkg::P31
                                                      : data_rd_a_reg;
    assign red2    = (red1 >= nttu_pkg::P31) ? red1 - nttu_pkg::P31 : red1;
    assign idx_ext = {12'd0, addr_a_q_reg};

    always_ff @(posedge clk)
    begin
        perm_addr_reg <= perm_waddr;
        addr_a_q_reg  <= addr_a;
        if (cmd.u_cap)
        begin
            u_reg <= (src_u >= nttu_pkg::P31) ? 30'(src_u - nttu_pkg::P31) : src_u[29:0];
        end
        if (cmd.tw_init)
        begin
            tw_reg <= 30'd1;
        end
        else if (cmd.tw_load)
        begin
            tw_reg <= mul_res;
        end
        if (cmd.out_load)
        begin
            value_reg     <= red2[29:0];
            out_index_reg <= idx_ext[11:0];
        end
    end

    assign value     = value_reg;
    assign out_index = out_index_reg;

endmodule

### sv/nttu_ctrl.sv
`timescale 1ns / 1ps

module nttu_ctrl #(
    parameter int MAX_LOG = 12,
    parameter int LGW     = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [11:0]          read_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [3:0]           cfg_data,
    input  nttu_pkg::status_t    status,
    output nttu_pkg::cmd_t       cmd,
    output logic [LGW-1:0]       stage,
    output logic [MAX_LOG-1:0]   addr_a,
    output logic [MAX_LOG-1:0]   addr_b,
    output logic [MAX_LOG-1:0]   wr_addr,
    output logic [MAX_LOG-1:0]   perm_waddr
);

    localparam int CW = MAX_LOG + 1;

    nttu_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]      load_count_reg, load_count_next;
    logic [CW-1:0]      base_reg, base_next;
    logic [MAX_LOG-1:0] i_reg, i_next;
    logic [LGW-1:0]     stage_reg, stage_next;
    logic               out_valid_reg, out_valid_next;
    logic [3:0]         log_size_reg;
    logic               inverse_reg;

    logic [LGW-1:0]     lg;
    logic [CW-1:0]      n;
    logic [CW-1:0]      half;
    logic [CW-1:0]      len;
    logic [CW-1:0]      addr_u_full;
    logic [CW-1:0]      addr_v_full;
    logic [MAX_LOG-1:0] rev_full;
    logic [MAX_LOG+11:0] idx_ext;
    logic               accept;

    assign lg   = (32'(log_size_reg) > MAX_LOG) ? LGW'(MAX_LOG) : LGW'(log_size_reg);
    assign n    = CW'(1) << lg;
    assign half = CW'(1) << (stage_reg - LGW'(1));
    assign len  = CW'(1) << stage_reg;
    assign addr_u_full = base_reg + {1'b0, i_reg};
    assign addr_v_full = addr_u_full + half;
    assign idx_ext     = {MAX_LOG'(0), read_index};

    always_comb
    begin
        for (int b = 0; b < MAX_LOG; b++)
        begin
            rev_full[b] = base_reg[MAX_LOG-1-b];
        end
    end

    assign perm_waddr = rev_full >> (MAX_LOG - int'(lg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_size_reg <= 4'd12;
            inverse_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                nttu_pkg::REG_LOG_SIZE:     log_size_reg <= cfg_data;
                nttu_pkg::REG_INVERSE_MODE: inverse_reg  <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nttu_pkg::ST_IDLE;
            load_count_reg <= '0;
            base_reg       <= '0;
            i_reg          <= '0;
            stage_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            base_reg       <= base_next;
            i_reg          <= i_next;
            stage_reg      <= stage_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        base_next       = base_reg;
        i_next          = i_reg;
        stage_next      = stage_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd             = '0;
        cmd.wr_sel      = nttu_pkg::WR_LOAD;
        cmd.mul_sel     = nttu_pkg::MUL_BFLY;
        cmd.inverse     = inverse_reg;
        in_ready        = 1'b0;
        accept          = 1'b0;
        addr_a          = addr_u_full[MAX_LOG-1:0];
        addr_b          = addr_v_full[MAX_LOG-1:0];
        wr_addr         = addr_u_full[MAX_LOG-1:0];

        case (state_reg)
            nttu_pkg::ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                accept   = in_valid && in_ready;
                addr_a   = idx_ext[MAX_LOG-1:0];
                if (accept)
                begin
                    if (func == nttu_pkg::FUNC_READ)
                    begin
                        state_next = nttu_pkg::ST_READ;
                    end
                    else
                    begin
                        cmd.mem_we = 1'b1;
                        wr_addr    = load_count_reg[MAX_LOG-1:0];
                        if (load_count_reg + CW'(1) >= n)
                        begin
                            load_count_next = '0;
                            base_next       = '0;
                            state_next      = nttu_pkg::ST_PERM;
                        end
                        else
                        begin
                            load_count_next = load_count_reg + CW'(1);
                        end
                    end
                end
            end
            nttu_pkg::ST_READ:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = nttu_pkg::ST_IDLE;
            end
            nttu_pkg::ST_PERM:
            begin
                addr_a      = base_reg[MAX_LOG-1:0];
                cmd.perm_rd = 1'b1;
                base_next   = base_reg + CW'(1);
                if (base_reg + CW'(1) == n)
                begin
                    state_next = nttu_pkg::ST_PERM_DRAIN;
                end
            end
            nttu_pkg::ST_PERM_DRAIN:
            begin
                if (lg == '0)
                begin
                    state_next = nttu_pkg::ST_IDLE;
                end
                else
                begin
                    stage_next  = LGW'(1);
                    i_next      = '0;
                    base_next   = '0;
                    cmd.tw_init = 1'b1;
                    state_next  = nttu_pkg::ST_BF_RD;
                end
            end
            nttu_pkg::ST_BF_RD:
            begin
                state_next = nttu_pkg::ST_BF_MUL;
            end
            nttu_pkg::ST_BF_MUL:
            begin
                cmd.src_scr   = (stage_reg == LGW'(1));
                cmd.u_cap     = 1'b1;
                cmd.mul_start = 1'b1;
                state_next    = nttu_pkg::ST_BF_WAIT;
            end
            nttu_pkg::ST_BF_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = nttu_pkg::ST_BF_WR0;
                end
            end
            nttu_pkg::ST_BF_WR0:
            begin
                cmd.mem_we = 1'b1;
                cmd.wr_sel = nttu_pkg::WR_SUM;
                state_next = nttu_pkg::ST_BF_WR1;
            end
            nttu_pkg::ST_BF_WR1:
            begin
                cmd.mem_we = 1'b1;
                cmd.wr_sel = nttu_pkg::WR_DIFF;
                wr_addr    = addr_v_full[MAX_LOG-1:0];
                if (base_reg + len < n)
                begin
                    base_next  = base_reg + len;
                    state_next = nttu_pkg::ST_BF_RD;
                end
                else if ({1'b0, i_reg} + CW'(1) < half)
                begin
                    i_next        = i_reg + MAX_LOG'(1);
                    base_next     = '0;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = nttu_pkg::MUL_TWID;
                    state_next    = nttu_pkg::ST_TW_WAIT;
                end
                else if (stage_reg == lg)
                begin
                    state_next = nttu_pkg::ST_IDLE;
                end
                else
                begin
                    stage_next  = stage_reg + LGW'(1);
                    i_next      = '0;
                    base_next   = '0;
                    cmd.tw_init = 1'b1;
                    state_next  = nttu_pkg::ST_BF_RD;
                end
            end
            nttu_pkg::ST_TW_WAIT:
            begin
                cmd.mul_sel = nttu_pkg::MUL_TWID;
                if (status.mul_done)
                begin
                    cmd.tw_load = 1'b1;
                    state_next  = nttu_pkg::ST_BF_RD;
                end
            end
            default:
            begin
                state_next = nttu_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign stage     = stage_reg;

endmodule

### sv/number_theoretic_transform_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    func, coefficient, read_index
// result    out        out_valid / out_ready  value, out_index
// config    in         cfg_wr_en              cfg_index, cfg_data
//
// A load transfer writes its coefficient to the store; a read transfer loads
// its result into the output register in the cycle after the read is taken.
// The load that completes 2^L coefficients starts the transform: a bit-reverse
// pass, then per butterfly a read, a multiply and writes of the sum and the
// difference ((L/2) * 2^L butterflies), plus twiddle updates between butterfly
// groups, paced by the modular multiplier and the single memory write port.
// Reset (rst_n low) clears control state and loads log_size 12, forward roots.
// in_ready stays low during the transform and while a result waits unaccepted.
module number_theoretic_transform_unit #(
    parameter int MAX_LOG = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [29:0] coefficient,
    input  logic [11:0] read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [29:0] value,
    output logic [11:0] out_index,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    // width of a stage number / effective length log
    localparam int LGW = $clog2(MAX_LOG + 1);

    nttu_pkg::cmd_t     cmd;
    nttu_pkg::status_t  status;
    logic [LGW-1:0]     stage;
    logic [MAX_LOG-1:0] addr_a;
    logic [MAX_LOG-1:0] addr_b;
    logic [MAX_LOG-1:0] wr_addr;
    logic [MAX_LOG-1:0] perm_waddr;

    // Sequencer: loads, reads, bit-reverse pass and butterfly stages
    nttu_ctrl #(
        .MAX_LOG (MAX_LOG),
        .LGW     (LGW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .cmd        (cmd),
        .stage      (stage),
        .addr_a     (addr_a),
        .addr_b     (addr_b),
        .wr_addr    (wr_addr),
        .perm_waddr (perm_waddr)
    );

    // Stores, modular multiplier, butterfly arithmetic, output register
    nttu_datapath #(
        .MAX_LOG (MAX_LOG),
        .LGW     (LGW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stage       (stage),
        .addr_a      (addr_a),
        .addr_b      (addr_b),
        .wr_addr     (wr_addr),
        .perm_waddr  (perm_waddr),
        .coefficient (coefficient),
        .status      (status),
        .value       (value),
        .out_index   (out_index)
    );

endmodule

### sv/nttu_checker.sv
`timescale 1ns / 1ps

module nttu_checker #(
    parameter int MAX_LOG = 12
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        func,
    input logic [11:0] read_index,
    input logic        out_valid,
    input logic        out_ready,
    input logic [29:0] value,
    input logic [11:0] out_index
);

    localparam logic [11:0] IDX_MASK = (MAX_LOG >= 12) ? 12'hFFF
                                                       : 12'((1 << MAX_LOG) - 1);

    logic rd_xfer;
    assign rd_xfer = in_valid && in_ready && (func == nttu_pkg::FUNC_READ);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(out_index))
        else $error("result changed while stalled");

    a_value_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> value < nttu_pkg::P30)
        else $error("result not fully reduced");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        rd_xfer |-> ##2 (out_valid && out_index == ($past(read_index, 2) & IDX_MASK)))
        else $error("read result missing or wrong index");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rd_xfer |=> !in_ready)
        else $error("input taken while a read is in flight");

endmodule

bind number_theoretic_transform_unit nttu_checker #(.MAX_LOG(MAX_LOG)) u_nttu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .read_index (read_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .out_index  (out_index)
);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int          STORE_N  = 4096;
    localparam int          TWID_N   = 2048;
    localparam logic [29:0] COEF_MAX = 30'd1053818880;

    typedef struct packed {
        logic        func;
        logic [29:0] coefficient;
        logic [11:0] read_index;
    } ntt_req_t;

    typedef struct packed {
        logic [29:0] value;
        logic [11:0] out_index;
    } ntt_elem_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        func        = nttu_pkg::FUNC_LOAD;
    logic [29:0] coefficient = '0;
    logic [11:0] read_index  = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [29:0] value;
    logic [11:0] out_index;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_index   = nttu_pkg::REG_LOG_SIZE;
    logic [3:0]  cfg_data    = '0;

    number_theoretic_transform_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .coefficient(coefficient),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .out_index  (out_index),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // Mirror of the block: element store, twiddle tables, load counter, registers
    logic [30:0] elem_store [STORE_N];
    logic [30:0] perm_store [STORE_N];
    logic [29:0] fwd_twiddle [TWID_N];
    logic [29:0] inv_twiddle [TWID_N];
    logic [12:0] loaded_count;
    logic [3:0]  length_log;
    logic        use_inverse;

    ntt_req_t    pending_reqs [$];
    ntt_elem_t   expected_elems [$];
    int          err_count = 0;
    int          item_count = 0;

    // Stimulus-side view: which entries have been loaded, where the next load lands
    bit          entry_loaded [STORE_N];
    int          loaded_list [$];
    int          plan_count = 0;
    int          plan_log = 12;
    int          slowest_log = 12;

    // Idle control
    int          send_gap = 0;
    int          recv_stall = 0;
    bit          quiet_tail = 1'b0;

    function automatic logic [63:0] mod_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) % nttu_pkg::MODULUS;
    endfunction

    function automatic logic [63:0] mod_pow(input logic [63:0] base_v, input logic [63:0] e);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq  = base_v % nttu_pkg::MODULUS;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_mul(acc, sq);
            sq = mod_mul(sq, sq);
            e  = e >> 1;
        end
        return acc;
    endfunction

    task automatic init_twiddles();
        logic [63:0] w;
        logic [63:0] wi;
        logic [63:0] a;
        logic [63:0] b;
        w  = mod_pow(nttu_pkg::PROOT, nttu_pkg::PHI >> 12);
        wi = mod_pow(w, nttu_pkg::PHI - 64'd1);
        a  = 64'd1;
        b  = 64'd1;
        for (int i = 0; i < TWID_N; i++)
        begin
            fwd_twiddle[i] = a[29:0];
            inv_twiddle[i] = b[29:0];
            a = mod_mul(a, w);
            b = mod_mul(b, wi);
        end
        for (int i = 0; i < STORE_N; i++)
        begin
            elem_store[i] = '0;
            perm_store[i] = '0;
        end
        loaded_count = '0;
        length_log   = 4'd12;
        use_inverse  = 1'b0;
    endtask

    // In-place decimation-in-time transform with lazy butterflies
    task automatic transform_block(input int lg);
        int          n;
        int          r;
        int          half;
        int          step;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] tw;
        n = 1 << lg;
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            for (int b = 0; b < lg; b++)
                if (i & (1 << b))
                    r |= 1 << (lg - 1 - b);
            perm_store[r] = elem_store[i];
        end
        for (int i = 0; i < n; i++)
            elem_store[i] = perm_store[i];
        for (int len = 2; len <= n; len <<= 1)
        begin
            half = len >> 1;
            step = STORE_N / len;
            for (int base_i = 0; base_i < n; base_i += len)
            begin
                for (int i = 0; i < half; i++)
                begin
                    u = 64'(elem_store[base_i + i]);
                    if (u >= nttu_pkg::MODULUS)
                        u -= nttu_pkg::MODULUS;
                    tw = use_inverse ? 64'(inv_twiddle[(i * step) & (TWID_N - 1)])
                                     : 64'(fwd_twiddle[(i * step) & (TWID_N - 1)]);
                    v = (64'(elem_store[base_i + i + half]) * tw) % nttu_pkg::MODULUS;
                    elem_store[base_i + i]        = 31'(u + v);
                    elem_store[base_i + i + half] = 31'(u + nttu_pkg::MODULUS - v);
                end
            end
        end
    endtask

    // Apply one accepted transfer to the mirror; a read queues its element
    task automatic apply_request(input ntt_req_t req);
        int          lg;
        logic [63:0] v;
        ntt_elem_t   e;
        if (req.func == nttu_pkg::FUNC_LOAD)
        begin
            lg = (length_log > 12) ? 12 : int'(length_log);
            elem_store[loaded_count[11:0]] = 31'(req.coefficient);
            loaded_count = loaded_count + 13'd1;
            if (int'(loaded_count) >= (1 << lg))
            begin
                transform_block(lg);
                loaded_count = '0;
            end
        end
        else
        begin
            v = 64'(elem_store[req.read_index]);
            if (v >= nttu_pkg::MODULUS)
                v -= nttu_pkg::MODULUS;
            if (v >= nttu_pkg::MODULUS)
                v -= nttu_pkg::MODULUS;
            e.value     = v[29:0];
            e.out_index = req.read_index;
            expected_elems.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Driver: present the next pending item, with random idle bursts
    always @(posedge clk)
    begin
        ntt_req_t req;
        logic     nxt_valid;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            if (in_valid && in_ready)
            begin
                apply_request('{func, coefficient, read_index});
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() > 0)
                begin
                    req         = pending_reqs.pop_front();
                    func        <= req.func;
                    coefficient <= req.coefficient;
                    read_index  <= req.read_index;
                    nxt_valid   = 1'b1;
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 13);
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // Monitor: check each result transfer against the oldest expected element
    always @(posedge clk)
    begin
        ntt_elem_t exp_e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_elems.size() == 0)
                    report_mismatch($sformatf("unexpected element idx %0d", out_index));
                else
                begin
                    exp_e = expected_elems.pop_front();
                    if (value !== exp_e.value)
                        report_mismatch($sformatf("value idx %0d got %0d want %0d",
                                                  exp_e.out_index, value, exp_e.value));
                    if (out_index !== exp_e.out_index)
                        report_mismatch($sformatf("out_index got %0d want %0d",
                                                  out_index, exp_e.out_index));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 8) == 0)
                    recv_stall = $urandom_range(1, 13);
            end
        end
    end

    task automatic push_load(input logic [29:0] c);
        pending_reqs.push_back('{nttu_pkg::FUNC_LOAD, c, 12'd0});
        if (!entry_loaded[plan_count & (STORE_N - 1)])
        begin
            entry_loaded[plan_count & (STORE_N - 1)] = 1'b1;
            loaded_list.push_back(plan_count & (STORE_N - 1));
        end
        plan_count++;
        if (plan_count >= (1 << plan_log))
            plan_count = 0;
        item_count++;
    endtask

    task automatic push_read(input int idx);
        pending_reqs.push_back('{nttu_pkg::FUNC_READ, 30'd0, 12'(idx)});
        item_count++;
    endtask

    task automatic push_read_any();
        push_read(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    endtask

    function automatic logic [29:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return COEF_MAX;
            1:       return 30'd0;
            default: return 30'($urandom_range(0, int'(COEF_MAX)));
        endcase
    endfunction

    // Hold until every result has come, then let any transform finish
    task automatic drain();
        int lat;
        while (pending_reqs.size() > 0 || in_valid || expected_elems.size() > 0)
            @(posedge clk);
        lat = (1 << slowest_log) * (4 * slowest_log + 8) + 200;
        repeat (lat) @(posedge clk);
        slowest_log = plan_log;
    endtask

    // Idle-only register write; mirror updated in the same step
    task automatic write_reg(input logic idx, input logic [3:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == nttu_pkg::REG_LOG_SIZE)
        begin
            length_log = data;
            plan_log   = (data > 12) ? 12 : int'(data);
            if (plan_log > slowest_log)
                slowest_log = plan_log;
            if (plan_count >= (1 << plan_log))
                plan_count = 1 << plan_log;
        end
        else
            use_inverse = data[0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(input int lg, input logic inv);
        write_reg(nttu_pkg::REG_LOG_SIZE, 4'(lg));
        write_reg(nttu_pkg::REG_INVERSE_MODE, {3'b0, inv});
    endtask

    initial
    begin
        int lg;
        int n;
        init_twiddles();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: length 4 with extreme coefficients, a raw read before the transform
        set_mode(2, 1'b0);
        push_load(COEF_MAX);
        push_read(0);
        push_load(30'd0);
        push_load(COEF_MAX);
        push_load(30'd1);
        for (int i = 0; i < 4; i++)
            push_read(i);
        drain();

        // Length 4 again with an impulse input, inverse roots
        set_mode(2, 1'b1);
        push_load(30'd1);
        push_load(30'd0);
        push_load(30'd0);
        push_load(30'd0);
        push_read(0);
        push_read(3);
        drain();

        // Length one: the transform is a plain copy
        set_mode(0, 1'b0);
        push_load(COEF_MAX);
        push_read(0);
        drain();

        // Shrink the length mid-load: the next load completes the block
        set_mode(3, 1'b0);
        for (int i = 0; i < 5; i++)
            push_load(rand_coef());
        drain();
        set_mode(2, 1'b1);
        push_load(rand_coef());
        push_read(1);
        push_read(5);
        drain();

        // Partial block at full length: raw reads across the loaded entries, up to index 1099
        set_mode(12, 1'b0);
        for (int i = 0; i < 1100; i++)
            push_load(rand_coef());
        for (int i = 0; i < 12; i++)
            push_read($urandom_range(0, 1099));
        push_read(1099);
        drain();

        // Shrink to 1024: the next load runs a long inverse transform
        set_mode(10, 1'b1);
        push_load(rand_coef());
        for (int i = 0; i < 16; i++)
            push_read_any();
        drain();

        // Random phases, mostly small lengths; some end mid-block
        while (item_count < 1900)
        begin
            lg = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 8);
            set_mode(lg, 1'($urandom_range(0, 1)));
            n = 1 << lg;
            repeat ($urandom_range(1, 3))
            begin
                for (int k = 0; k < n; k++)
                begin
                    push_load(rand_coef());
                    if ($urandom_range(0, 3) == 0)
                        push_read_any();
                end
                repeat ($urandom_range(2, 8)) push_read_any();
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(0, n)) push_load(rand_coef());
            if (item_count > 1500)
                quiet_tail = 1'b1;
            drain();
        end

        if (err_count == 0 && expected_elems.size() == 0)
            $display("[number_theoretic_transform_unit] OK");
        else
            $display("[number_theoretic_transform_unit] ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("[number_theoretic_transform_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
sv/nttu_pkg.sv
sv/nttu_modmul.sv
sv/nttu_datapath.sv
sv/nttu_ctrl.sv
sv/number_theoretic_transform_unit.sv
sv/nttu_checker.sv
tb/tb.sv
